[rtl/slab_page_chunk_allocator_defines.svh]
// Assertion macros for the slab page chunk allocator RTL.
`ifndef SLAB_PAGE_CHUNK_ALLOCATOR_DEFINES_SVH
`define SLAB_PAGE_CHUNK_ALLOCATOR_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define SPCA_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define SPCA_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define SPCA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/spca_pkg.sv]
package spca_pkg;

    localparam int MAX_CHUNKS_DEF = 256;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam int OFF_W      = 12;
    localparam int USABLE_W   = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int ROW_W      = 16;
    localparam int BIT_W      = 4;
    localparam int STEP_W     = 4;
    localparam int MIN_CHUNK  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_SIZE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_OFFSET  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_USABLE_CHUNKS = 2'd2;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_NO_FREE      = 2'd1;
    localparam logic [1:0] ST_WRONG        = 2'd2;
    localparam logic [1:0] ST_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic             cmd;
        logic [OFF_W-1:0] chunk_offset;
    } req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [OFF_W-1:0] result_offset;
        logic             page_now_full;
        logic             page_left_full;
        logic             page_now_empty;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_MUL,
        S_MARK,
        S_SUB,
        S_DIV,
        S_BIT_RD,
        S_BIT_CHK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic           sub;
        logic [OFF_W:0] a;
        logic [OFF_W:0] b;
    } alu_req_t;

    typedef struct packed {
        logic           carry;
        logic [OFF_W:0] sum;
    } alu_rsp_t;

endpackage

[rtl/slab_page_chunk_allocator.sv]
// Chunk allocator for one slab page: one word in, one word out per request.
// A request is taken only while the sequencer is idle; a finished word sits in
// the output register, so the next request may enter while it waits.
// Allocate on an active page scans the bitmap one 16-chunk row at a time
// (registered RAM read, then lowest-free search), then forms
// first_offset + index * chunk_size with one shift-add step per index bit on
// the shared adder. Free runs a restoring divide by chunk_size, one quotient
// bit per cycle on the same adder, then a read-modify-write of the row. First
// allocation of a page and any request rejected up front go straight to the
// result state. Row valid bits make a page release and reset take effect at
// once; there is no clearing pass.
`include "slab_page_chunk_allocator_defines.svh"

module slab_page_chunk_allocator #(
    parameter int MAX_CHUNKS = spca_pkg::MAX_CHUNKS_DEF,
    parameter int PAGE_BYTES = spca_pkg::PAGE_BYTES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [spca_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spca_pkg::OFF_W-1:0]          cfg_data,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  spca_pkg::req_t                      req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output spca_pkg::rsp_t                      rsp
);

    localparam int OFF_W     = spca_pkg::OFF_W;
    localparam int ROW_W     = spca_pkg::ROW_W;
    localparam int BIT_W     = spca_pkg::BIT_W;
    localparam int STEP_W    = spca_pkg::STEP_W;
    localparam int ROWS      = (MAX_CHUNKS + ROW_W - 1) / ROW_W;
    localparam int ROW_AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ROW_SLOTS = 1 << ROW_AW;
    localparam int IDX_W     = ROW_AW + BIT_W;
    localparam int CNT_W     = $clog2(MAX_CHUNKS + 1);
    localparam int CMP_W     = IDX_W + 1;
    localparam int UW        = (CMP_W > spca_pkg::USABLE_W) ? CMP_W : spca_pkg::USABLE_W;
    localparam logic [OFF_W-1:0] POS_MASK =
        (PAGE_BYTES >= (1 << OFF_W)) ? {OFF_W{1'b1}} : OFF_W'(PAGE_BYTES - 1);

    spca_pkg::state_t state_reg, state_next;

    logic [OFF_W-1:0]              size_reg;
    logic [OFF_W-1:0]              first_reg;
    logic [spca_pkg::USABLE_W-1:0] usable_reg;

    logic [CNT_W-1:0]     fc_reg, fc_next;
    logic                 active_reg, active_next;
    logic [ROW_SLOTS-1:0] rvalid_reg, rvalid_next;
    logic                 rsp_valid_reg, rsp_valid_next;
    spca_pkg::rsp_t       rsp_reg, rsp_next;
    spca_pkg::rsp_t       pend_reg, pend_next;

    logic [ROW_AW-1:0] row_reg, row_next;
    logic [BIT_W-1:0]  bit_reg, bit_next;
    logic [ROW_W-1:0]  rowdata_reg, rowdata_next;
    logic [OFF_W:0]    rem_reg, rem_next;
    logic [OFF_W-1:0]  quo_reg, quo_next;
    logic [OFF_W-1:0]  acc_reg, acc_next;
    logic [OFF_W-1:0]  mcand_reg, mcand_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [OFF_W-1:0]  pos_reg, pos_next;

    logic              ram_we;
    logic [ROW_AW-1:0] ram_waddr;
    logic [ROW_W-1:0]  ram_wdata;
    logic [ROW_AW-1:0] ram_raddr;
    logic [ROW_W-1:0]  ram_rdata;

    spca_pkg::alu_req_t alu_req;
    spca_pkg::alu_rsp_t alu_rsp;

    logic [OFF_W-1:0] eff_size;
    logic [UW-1:0]    usable_u;
    logic [UW-1:0]    eff_usable;
    logic [ROW_W-1:0] eff_row;
    logic [ROW_W-1:0] free_vec;
    logic             found;
    logic [BIT_W-1:0] fbit;
    logic [IDX_W-1:0] base_idx;
    logic             last_row;
    logic [OFF_W:0]   div_shift;
    logic [CNT_W-1:0] fc_inc;
    logic             accept;

    spca_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    spca_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    assign req_stall = (state_reg != spca_pkg::S_IDLE);
    assign accept    = req_valid && !req_stall;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Sizes below the minimum act as the minimum; usable count is clamped.
    assign eff_size = (size_reg < OFF_W'(spca_pkg::MIN_CHUNK)) ?
                      OFF_W'(spca_pkg::MIN_CHUNK) : size_reg;
    assign usable_u = UW'(usable_reg);

    always_comb
    begin
        if (usable_u == '0)
        begin
            eff_usable = UW'(1);
        end
        else if (usable_u > UW'(MAX_CHUNKS))
        begin
            eff_usable = UW'(MAX_CHUNKS);
        end
        else
        begin
            eff_usable = usable_u;
        end
    end

    // A row never written since the last release reads as all free.
    assign eff_row   = rvalid_reg[row_reg] ? ram_rdata : '0;
    assign base_idx  = {row_reg, BIT_W'(0)};
    assign last_row  = (UW'(base_idx) + UW'(ROW_W)) >= eff_usable;
    assign div_shift = {rem_reg[OFF_W-1:0], quo_reg[OFF_W-1]};
    assign fc_inc    = fc_reg + CNT_W'(1);

    always_comb
    begin
        for (int b = 0; b < ROW_W; b++)
        begin
            free_vec[b] = !eff_row[b] && ((UW'(base_idx) + UW'(b)) < eff_usable);
        end
    end

    // Lowest free chunk of the row.
    always_comb
    begin
        found = 1'b0;
        fbit  = '0;
        for (int b = ROW_W - 1; b >= 0; b--)
        begin
            if (free_vec[b])
            begin
                found = 1'b1;
                fbit  = BIT_W'(b);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spca_pkg::S_IDLE;
            size_reg      <= OFF_W'(spca_pkg::MIN_CHUNK);
            first_reg     <= '0;
            usable_reg    <= spca_pkg::USABLE_W'(256);
            fc_reg        <= '0;
            active_reg    <= 1'b0;
            rvalid_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fc_reg        <= fc_next;
            active_reg    <= active_next;
            rvalid_reg    <= rvalid_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    spca_pkg::CFG_CHUNK_SIZE:    size_reg   <= cfg_data;
                    spca_pkg::CFG_FIRST_OFFSET:  first_reg  <= cfg_data;
                    spca_pkg::CFG_USABLE_CHUNKS:
                        usable_reg <= cfg_data[spca_pkg::USABLE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg     <= rsp_next;
        pend_reg    <= pend_next;
        row_reg     <= row_next;
        bit_reg     <= bit_next;
        rowdata_reg <= rowdata_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        acc_reg     <= acc_next;
        mcand_reg   <= mcand_next;
        step_reg    <= step_next;
        pos_reg     <= pos_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fc_next        = fc_reg;
        active_next    = active_reg;
        rvalid_next    = rvalid_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        rsp_next       = rsp_reg;
        pend_next      = pend_reg;
        row_next       = row_reg;
        bit_next       = bit_reg;
        rowdata_next   = rowdata_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        ram_we         = 1'b0;
        ram_waddr      = row_reg;
        ram_wdata      = rowdata_reg;
        ram_raddr      = row_reg;
        alu_req        = '0;

        unique case (state_reg)
            spca_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    pend_next = '0;
                    if (req.cmd == spca_pkg::CMD_ALLOC)
                    begin
                        if (!active_reg)
                        begin
                            // Open the page and take chunk zero.
                            ram_we                  = 1'b1;
                            ram_waddr               = '0;
                            ram_wdata               = ROW_W'(1);
                            rvalid_next             = ROW_SLOTS'(1);
                            active_next             = 1'b1;
                            fc_next                 = CNT_W'(eff_usable - UW'(1));
                            pend_next.result_offset = first_reg;
                            pend_next.page_now_full = (eff_usable == UW'(1));
                            state_next              = spca_pkg::S_DONE;
                        end
                        else if (fc_reg == '0)
                        begin
                            pend_next.status = spca_pkg::ST_NO_FREE;
                            state_next       = spca_pkg::S_DONE;
                        end
                        else
                        begin
                            row_next   = '0;
                            state_next = spca_pkg::S_SCAN_RD;
                        end
                    end
                    else
                    begin
                        if (!active_reg)
                        begin
                            pend_next.status = spca_pkg::ST_ALREADY_FREE;
                            state_next       = spca_pkg::S_DONE;
                        end
                        else
                        begin
                            pos_next   = req.chunk_offset & POS_MASK;
                            state_next = spca_pkg::S_SUB;
                        end
                    end
                end
            end

            spca_pkg::S_SCAN_RD:
            begin
                state_next = spca_pkg::S_SCAN_CHK;
            end

            spca_pkg::S_SCAN_CHK:
            begin
                if (found)
                begin
                    rowdata_next = eff_row;
                    bit_next     = fbit;
                    quo_next     = OFF_W'({row_reg, fbit});
                    acc_next     = first_reg;
                    mcand_next   = eff_size;
                    step_next    = '0;
                    state_next   = spca_pkg::S_MUL;
                end
                else if (last_row)
                begin
                    pend_next.status = spca_pkg::ST_NO_FREE;
                    state_next       = spca_pkg::S_DONE;
                end
                else
                begin
                    row_next   = row_reg + ROW_AW'(1);
                    state_next = spca_pkg::S_SCAN_RD;
                end
            end

            spca_pkg::S_MUL:
            begin
                // Shift-add: the offset wraps to 12 bits, so the product may too.
                alu_req.sub = 1'b0;
                alu_req.a   = {1'b0, acc_reg};
                alu_req.b   = {1'b0, mcand_reg};
                if (quo_reg[0])
                begin
                    acc_next = alu_rsp.sum[OFF_W-1:0];
                end
                mcand_next = mcand_reg << 1;
                quo_next   = quo_reg >> 1;
                step_next  = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(IDX_W - 1))
                begin
                    state_next = spca_pkg::S_MARK;
                end
            end

            spca_pkg::S_MARK:
            begin
                ram_we                  = 1'b1;
                ram_wdata               = rowdata_reg | (ROW_W'(1) << bit_reg);
                rvalid_next[row_reg]    = 1'b1;
                fc_next                 = fc_reg - CNT_W'(1);
                pend_next.result_offset = acc_reg;
                pend_next.page_now_full = (fc_reg == CNT_W'(1));
                state_next              = spca_pkg::S_DONE;
            end

            spca_pkg::S_SUB:
            begin
                alu_req.sub = 1'b1;
                alu_req.a   = {1'b0, pos_reg};
                alu_req.b   = {1'b0, first_reg};
                if (!alu_rsp.carry)
                begin
                    pend_next.status = spca_pkg::ST_WRONG;
                    state_next       = spca_pkg::S_DONE;
                end
                else
                begin
                    quo_next   = alu_rsp.sum[OFF_W-1:0];
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = spca_pkg::S_DIV;
                end
            end

            spca_pkg::S_DIV:
            begin
                // Restoring divide, one quotient bit per cycle.
                alu_req.sub = 1'b1;
                alu_req.a   = div_shift;
                alu_req.b   = {1'b0, eff_size};
                rem_next    = alu_rsp.carry ? alu_rsp.sum : div_shift;
                quo_next    = {quo_reg[OFF_W-2:0], alu_rsp.carry};
                step_next   = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(OFF_W - 1))
                begin
                    state_next = spca_pkg::S_BIT_RD;
                end
            end

            spca_pkg::S_BIT_RD:
            begin
                ram_raddr = quo_reg[IDX_W-1:BIT_W];
                if ((rem_reg != '0) || (quo_reg >= OFF_W'(eff_usable)))
                begin
                    pend_next.status = spca_pkg::ST_WRONG;
                    state_next       = spca_pkg::S_DONE;
                end
                else
                begin
                    row_next   = quo_reg[IDX_W-1:BIT_W];
                    bit_next   = quo_reg[BIT_W-1:0];
                    state_next = spca_pkg::S_BIT_CHK;
                end
            end

            spca_pkg::S_BIT_CHK:
            begin
                if (!eff_row[bit_reg])
                begin
                    pend_next.status = spca_pkg::ST_ALREADY_FREE;
                end
                else
                begin
                    ram_we                   = 1'b1;
                    ram_wdata                = eff_row & ~(ROW_W'(1) << bit_reg);
                    rvalid_next[row_reg]     = 1'b1;
                    pend_next.page_left_full = (fc_reg == '0);
                    if (UW'(fc_inc) >= eff_usable)
                    begin
                        // Last busy chunk gone: release the page.
                        rvalid_next              = '0;
                        fc_next                  = '0;
                        active_next              = 1'b0;
                        pend_next.page_now_empty = 1'b1;
                    end
                    else
                    begin
                        fc_next = fc_inc;
                    end
                end
                state_next = spca_pkg::S_DONE;
            end

            spca_pkg::S_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next       = pend_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = spca_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = spca_pkg::S_IDLE;
            end
        endcase
    end

    `SPCA_ASSERT_ALWAYS(a_fc_range, clk, rst_n, fc_reg <= CNT_W'(MAX_CHUNKS), "free count above chunk count")
    `SPCA_ASSERT_IMPLY(a_idle_page_count, clk, rst_n, !active_reg, fc_reg == '0, "released page has nonzero free count")
    `SPCA_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, state_reg != spca_pkg::S_IDLE, "accepted word left sequencer idle")
    `SPCA_ASSERT_IMPLY(a_error_clean, clk, rst_n, rsp_valid && (rsp.status != spca_pkg::ST_OK), (rsp.result_offset == '0) && !rsp.page_now_full && !rsp.page_left_full && !rsp.page_now_empty, "error word carries offset or flags")

endmodule

[rtl/spca_ram.sv]
module spca_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/spca_alu.sv]
module spca_alu (
    input  spca_pkg::alu_req_t req,
    output spca_pkg::alu_rsp_t rsp
);

    logic [spca_pkg::OFF_W:0]   b_op;
    logic [spca_pkg::OFF_W+1:0] total;

    // Subtract as add of the complement; carry out set means no borrow.
    assign b_op  = req.sub ? ~req.b : req.b;
    assign total = {1'b0, req.a} + {1'b0, b_op} + (spca_pkg::OFF_W + 2)'(req.sub);

    assign rsp.carry = total[spca_pkg::OFF_W+1];
    assign rsp.sum   = total[spca_pkg::OFF_W:0];

endmodule

[verif/tb_top.sv]
module tb_top;
    import spca_pkg::*;

    // Mirror of the page: bitmap, free count and the three registers.
    class page_ledger;
        int unsigned size_reg;
        int unsigned first_reg;
        int unsigned usable_reg;
        bit [MAX_CHUNKS_DEF-1:0] busy;
        int unsigned free_left;
        bit in_use;
        rsp_t expected_rsp[$];
        int unsigned bad_words;

        function new();
            size_reg = MIN_CHUNK;
            first_reg = 0;
            usable_reg = MAX_CHUNKS_DEF;
            busy = '0;
            free_left = 0;
            in_use = 1'b0;
            bad_words = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [OFF_W-1:0] data);
            case (idx)
                CFG_CHUNK_SIZE:    size_reg = data;
                CFG_FIRST_OFFSET:  first_reg = data;
                CFG_USABLE_CHUNKS: usable_reg = data[USABLE_W-1:0];
                default: ;
            endcase
        endfunction

        function int unsigned chunk_bytes();
            return (size_reg < MIN_CHUNK) ? MIN_CHUNK : size_reg;
        endfunction

        function int unsigned usable_count();
            if (usable_reg == 0)
                return 1;
            if (usable_reg > MAX_CHUNKS_DEF)
                return MAX_CHUNKS_DEF;
            return usable_reg;
        endfunction

        function logic [OFF_W-1:0] chunk_at(int unsigned idx);
            return OFF_W'(first_reg + idx * chunk_bytes());
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        // Offset of a random busy chunk, if there is one.
        function bit pick_busy(output logic [OFF_W-1:0] off);
            int unsigned n;
            int unsigned k;
            off = '0;
            n = $countones(busy);
            if (n == 0)
                return 1'b0;
            k = $urandom_range(n - 1);
            for (int unsigned j = 0; j < MAX_CHUNKS_DEF; j++)
            begin
                if (busy[j])
                begin
                    if (k == 0)
                    begin
                        off = chunk_at(j);
                        return 1'b1;
                    end
                    k--;
                end
            end
            return 1'b0;
        endfunction

        function void take_request(req_t r);
            rsp_t o;
            int unsigned csize;
            int unsigned usable;
            int unsigned i;
            int unsigned pos;
            int unsigned d;
            int unsigned idx;
            bit found;
            o = '0;
            o.status = ST_OK;
            csize = chunk_bytes();
            usable = usable_count();
            if (r.cmd == CMD_ALLOC)
            begin
                if (!in_use)
                begin
                    // open the page: chunk zero goes first
                    busy = '0;
                    in_use = 1'b1;
                    busy[0] = 1'b1;
                    free_left = usable - 1;
                    o.result_offset = OFF_W'(first_reg);
                    o.page_now_full = (free_left == 0);
                end
                else if (free_left == 0)
                    o.status = ST_NO_FREE;
                else
                begin
                    found = 1'b0;
                    for (i = 0; i < usable; i++)
                    begin
                        if (!busy[i])
                        begin
                            found = 1'b1;
                            break;
                        end
                    end
                    if (!found)
                        o.status = ST_NO_FREE;
                    else
                    begin
                        busy[i] = 1'b1;
                        free_left--;
                        o.result_offset = chunk_at(i);
                        o.page_now_full = (free_left == 0);
                    end
                end
            end
            else
            begin
                pos = r.chunk_offset;
                if (!in_use)
                    o.status = ST_ALREADY_FREE;
                else if (pos < first_reg)
                    o.status = ST_WRONG;
                else
                begin
                    d = pos - first_reg;
                    idx = d / csize;
                    if (d != idx * csize || idx >= usable)
                        o.status = ST_WRONG;
                    else if (!busy[idx])
                        o.status = ST_ALREADY_FREE;
                    else
                    begin
                        busy[idx] = 1'b0;
                        o.page_left_full = (free_left == 0);
                        free_left++;
                        // release the page once nothing is held
                        if (free_left >= usable)
                        begin
                            busy = '0;
                            free_left = 0;
                            in_use = 1'b0;
                            o.page_now_empty = 1'b1;
                        end
                    end
                end
            end
            expected_rsp.push_back(o);
        endfunction

        function void check_word(rsp_t got);
            rsp_t want;
            if (expected_rsp.size() == 0)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("unexpected result word: status %0d offset %0d flags %b%b%b",
                             got.status, got.result_offset, got.page_now_full,
                             got.page_left_full, got.page_now_empty);
                return;
            end
            want = expected_rsp.pop_front();
            if (got.status !== want.status || got.result_offset !== want.result_offset
                || got.page_now_full !== want.page_now_full
                || got.page_left_full !== want.page_left_full
                || got.page_now_empty !== want.page_now_empty)
            begin
                bad_words++;
                if (bad_words <= 10)
                    $display("word mismatch: status exp %0d got %0d, offset exp %0d got %0d, %s",
                             want.status, got.status, want.result_offset, got.result_offset,
                             $sformatf("full/left/empty exp %b%b%b got %b%b%b",
                                       want.page_now_full, want.page_left_full,
                                       want.page_now_empty, got.page_now_full,
                                       got.page_left_full, got.page_now_empty));
            end
        endfunction
    endclass

    localparam int STUCK_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [OFF_W-1:0] cfg_data;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;

    page_ledger page = new();
    bit quiet = 1'b0;
    bit hold_req = 1'b0;
    int stuck_cycles = 0;

    slab_page_chunk_allocator dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Receiver: random stalls, one long hold-off on request.
    initial
    begin
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                rsp_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            rsp_stall = !quiet && ($urandom_range(99) < 11);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && !rsp_stall)
            page.check_word(rsp);
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= STUCK_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Entered and left at a falling edge; hold the word until taken.
    task automatic send_request(input logic cmd, input logic [OFF_W-1:0] off);
        req_t item;
        item.cmd = cmd;
        item.chunk_offset = off;
        while (!quiet && $urandom_range(99) < 11)
        begin
            req_valid = 1'b0;
            @(negedge clk);
        end
        req_valid = 1'b1;
        req = item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        page.take_request(item);
        @(negedge clk);
    endtask

    task automatic drain();
        req_valid = 1'b0;
        while (page.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [OFF_W-1:0] data);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        page.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic program_page(input int unsigned csize, input int unsigned first,
                                input int unsigned usable);
        drain();
        write_cfg(CFG_CHUNK_SIZE, OFF_W'(csize));
        write_cfg(CFG_FIRST_OFFSET, OFF_W'(first));
        write_cfg(CFG_USABLE_CHUNKS, OFF_W'(usable));
    endtask

    // Mostly allocations and frees of held chunks; the rest is noise.
    task automatic run_phase(input int n, input int alloc_pct, input bit pause_mid,
                             input bit hold_mid);
        int unsigned r;
        logic [OFF_W-1:0] off;
        for (int k = 0; k < n; k++)
        begin
            if (k == n / 2)
            begin
                if (pause_mid)
                    drain();
                if (hold_mid)
                    hold_req = 1'b1;
            end
            r = $urandom_range(99);
            off = OFF_W'($urandom);
            if (r < alloc_pct)
                send_request(CMD_ALLOC, off);
            else if (r < 92 && page.pick_busy(off))
                send_request(CMD_FREE, off);
            else if (r < 96)
            begin
                off = page.chunk_at($urandom_range(page.usable_count() - 1));
                if (r == 95)
                    off = off + OFF_W'($urandom_range(1, 15));
                send_request(CMD_FREE, off);
            end
            else
                send_request(CMD_FREE, off);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_CHUNK_SIZE;
        cfg_data = '0;
        req_valid = 1'b0;
        req = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // default registers: 16-byte chunks from offset 0, 256 usable
        send_request(CMD_FREE, 12'd0);
        send_request(CMD_ALLOC, 12'hFFF);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_ALLOC, 12'h800);
        send_request(CMD_FREE, 12'd8);
        send_request(CMD_FREE, 12'hFFF);
        send_request(CMD_FREE, 12'd48);
        send_request(CMD_FREE, 12'd16);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd0);
        send_request(CMD_FREE, 12'd16);
        send_request(CMD_FREE, 12'd32);

        // single usable chunk
        program_page(32, 100, 1);
        send_request(CMD_FREE, 12'd132);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd50);
        send_request(CMD_FREE, 12'd132);
        send_request(CMD_FREE, 12'd100);

        // shrink the usable count under an active page
        program_page(16, 0, 4);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_ALLOC, 12'd0);
        program_page(16, 0, 2);
        send_request(CMD_ALLOC, 12'd0);
        send_request(CMD_FREE, 12'd0);

        program_page(16, 0, 8);
        run_phase(150, 60, 1'b0, 1'b0);
        program_page(2048, 0, 2);
        run_phase(100, 55, 1'b0, 1'b0);
        quiet = 1'b1;
        program_page(48, 100, 20);
        run_phase(150, 60, 1'b0, 1'b0);
        quiet = 1'b0;
        program_page(0, 4095, 3);
        run_phase(80, 55, 1'b0, 1'b0);
        program_page(5, 7, 16);
        run_phase(100, 55, 1'b1, 1'b0);
        program_page(4095, 1, 0);
        run_phase(60, 50, 1'b0, 1'b0);
        program_page(16, 0, 256);
        run_phase(400, 92, 1'b0, 1'b1);
        program_page(1000, 33, 511);
        run_phase(100, 60, 1'b0, 1'b0);
        program_page(64, 0, 40);
        run_phase(150, 65, 1'b0, 1'b0);
        program_page(64, 0, 4);
        run_phase(60, 50, 1'b0, 1'b0);

        drain();
        repeat (60) @(negedge clk);
        if (page.bad_words == 0 && page.pending() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
